/* sv/dscs_pkg.sv */
package dscs_pkg;

  // Sector geometry
  localparam int SECTOR_WORDS = 1024;
  localparam int SEC_AW       = $clog2(SECTOR_WORDS);
  localparam int CTR_W        = $clog2(2 * SECTOR_WORDS);
  localparam int CFG_W        = 10;
  localparam int CMP_W        = (SEC_AW > CFG_W) ? SEC_AW : CFG_W;

  localparam logic [CFG_W-1:0] SEQ_IDX_RST = CFG_W'(1021);

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef logic [31:0] crc_tab_t [256];

  typedef struct packed {
    logic [31:0] data_word;
    logic        pair_start;
  } dscs_in_t;

  typedef struct packed {
    logic        current_sector;
    logic        sector0_valid;
    logic        sector1_valid;
    logic        needs_init;
    logic [31:0] current_seq;
  } dscs_out_t;

  // Build the byte-wise lookup table at elaboration
  function automatic crc_tab_t crc_gen_table();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_gen_table();

  // Advance the CRC over one word, least significant byte first
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc;
    for (int b = 0; b < 4; b++) begin
      c = (c >> 8) ^ CRC_TABLE[c[7:0] ^ w[8*b +: 8]];
    end
    return c;
  endfunction

endpackage

/* sv/dscs_core.sv */
module dscs_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  dscs_pkg::dscs_in_t         req,
  input  logic [dscs_pkg::CFG_W-1:0] seq_idx,
  output logic                       res_vld,
  output dscs_pkg::dscs_out_t        res
);
  import dscs_pkg::*;

  logic [31:0]       crc_r, crc_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic [31:0]       seq0_r, seq0_nxt;
  logic [31:0]       seq1_r, seq1_nxt;
  logic              fv_r, fv_nxt;

  logic [31:0]       crc_eff;
  logic [CTR_W-1:0]  ctr_eff;
  logic              sector;
  logic [SEC_AW-1:0] pos;
  logic              hit;
  logic              last;
  logic              crc_ok;
  logic [31:0]       seq1_eff;
  logic              cur;

  // Restart the pair on a start marker
  assign crc_eff = req.pair_start ? CRC_ONES : crc_r;
  assign ctr_eff = req.pair_start ? '0 : ctr_r;

  // Split the pair position into sector and word
  assign sector = (ctr_eff >= CTR_W'(SECTOR_WORDS));
  assign pos    = sector ? SEC_AW'(ctr_eff - CTR_W'(SECTOR_WORDS)) : SEC_AW'(ctr_eff);
  assign hit    = (CMP_W'(pos) == CMP_W'(seq_idx));
  assign last   = (pos == SEC_AW'(SECTOR_WORDS - 1));
  assign crc_ok = ((crc_eff ^ CRC_ONES) == req.data_word);

  // Pick the current copy on the last word of sector one
  assign seq1_eff = (hit && sector) ? req.data_word : seq1_r;

  always_comb begin
    if (fv_r && crc_ok) begin
      cur = !(seq0_r > seq1_eff);
    end else if (fv_r) begin
      cur = 1'b0;
    end else begin
      cur = 1'b1;
    end
  end

  assign res_vld            = last && sector;
  assign res.current_sector = cur;
  assign res.sector0_valid  = fv_r;
  assign res.sector1_valid  = crc_ok;
  assign res.needs_init     = !fv_r && !crc_ok;
  assign res.current_seq    = cur ? seq1_eff : seq0_r;

  // Advance the running state for one request
  always_comb begin
    crc_nxt  = crc_r;
    ctr_nxt  = ctr_r;
    seq0_nxt = seq0_r;
    seq1_nxt = seq1_r;
    fv_nxt   = fv_r;
    if (fire) begin
      if (hit && !sector) begin
        seq0_nxt = req.data_word;
      end
      if (hit && sector) begin
        seq1_nxt = req.data_word;
      end
      if (!last) begin
        crc_nxt = crc_word(crc_eff, req.data_word);
        ctr_nxt = ctr_eff + CTR_W'(1);
      end else begin
        crc_nxt = CRC_ONES;
        if (!sector) begin
          fv_nxt  = crc_ok;
          ctr_nxt = ctr_eff + CTR_W'(1);
        end else begin
          ctr_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_ONES;
      ctr_r  <= '0;
      seq0_r <= '0;
      seq1_r <= '0;
      fv_r   <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      ctr_r  <= ctr_nxt;
      seq0_r <= seq0_nxt;
      seq1_r <= seq1_nxt;
      fv_r   <= fv_nxt;
    end
  end

endmodule

/* sv/dual_sector_crc_selector_unit.sv */
// Streams the words of two redundant flash sectors (sector zero, then sector
// one, SECTOR_WORDS words each) and reports which copy is current. Each sector
// is checked with reflected CRC-32 over all words but its last, which holds the
// stored CRC; the word at cfg_wr_data's configured index is the copy's sequence
// number. One request is taken every clock while the result side is not
// stalled: the input register feeds combinational logic (a four-byte table
// lookup chain for the CRC and a 32-bit sequence compare) into the result
// register, so the block sustains one word per cycle. A result appears only
// for the last word of sector one; pair_start restarts the pair at any word.
// The sequence index register may be written only while no request is in
// flight.
module dual_sector_crc_selector_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dscs_pkg::dscs_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dscs_pkg::dscs_out_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [dscs_pkg::CFG_W-1:0] cfg_wr_data
);
  import dscs_pkg::*;

  logic [CFG_W-1:0] seq_idx_r;
  logic             in_vld_r;
  dscs_in_t         in_req_r;
  logic             out_vld_r;
  dscs_out_t        out_res_r;

  logic             advance;
  logic             accept;
  logic             fire;
  logic             res_vld;
  dscs_out_t        res;

  // Move forward whenever the result register is free or draining
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = in_vld_r && advance;

  // Hold the sequence index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_idx_r <= SEQ_IDX_RST;
    end else if (cfg_wr_en) begin
      seq_idx_r <= cfg_wr_data;
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req_r <= in_data;
    end
  end

  dscs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .req     (in_req_r),
    .seq_idx (seq_idx_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

endmodule

/* sv/dscs_checker.sv */
module dscs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_stall,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dscs_pkg::dscs_out_t out_data
);
  import dscs_pkg::*;

  // Input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Both copies bad selects copy one
  a_init_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.needs_init) |->
      (out_data.current_sector && !out_data.sector0_valid && !out_data.sector1_valid))
    else $error("needs_init inconsistent with validity");

  // Only copy zero good selects copy zero
  a_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.sector0_valid && !out_data.sector1_valid) |->
      !out_data.current_sector)
    else $error("valid copy zero not selected");

  // Only copy one good selects copy one
  a_second_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.sector0_valid && out_data.sector1_valid) |->
      (out_data.current_sector && !out_data.needs_init))
    else $error("valid copy one not selected");

endmodule

bind dual_sector_crc_selector_unit dscs_checker u_dscs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dscs_pkg::*;

  localparam int unsigned RUN_LIMIT = 50_000_000;

  // How the sequence words of a generated pair relate to each other
  typedef enum int unsigned {
    SEQ_RANDOM,
    SEQ_TIE,
    SEQ_FIRST_AHEAD,
    SEQ_SECOND_AHEAD,
    SEQ_EXTREMES
  } seq_pattern_t;

  // One queued sector word and the idle cycles that follow its acceptance
  typedef struct {
    dscs_in_t    req;
    int unsigned gap;
  } word_slot_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  dscs_in_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  dscs_out_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = SEQ_IDX_RST;

  word_slot_t  sector_words[$];
  dscs_out_t   pending_verdicts[$];
  int unsigned idle_left     = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned full_pairs    = 0;
  bit          at_pair_edge  = 1'b1;

  // Shadow of the selector state
  logic [CFG_W-1:0] seq_idx   = SEQ_IDX_RST;
  logic [31:0]      crc_acc   = CRC_ONES;
  int unsigned      pair_pos  = 0;
  logic [31:0]      copy0_seq = '0;
  logic [31:0]      copy1_seq = '0;
  logic             copy0_ok  = 1'b0;

  dual_sector_crc_selector_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Reflected CRC-32 over one word, bit at a time, low byte first
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [31:0] w);
    int b;
    c = c ^ w;
    for (b = 0; b < 32; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the shadow state by one accepted request; queue the verdict on
  // the last word of sector one
  function automatic void track_sector_word(input dscs_in_t req);
    int unsigned sect, offs;
    logic        ok, pick;
    dscs_out_t   verdict;
    if (req.pair_start) begin
      pair_pos = 0;
      crc_acc  = CRC_ONES;
    end
    if (pair_pos >= 2 * SECTOR_WORDS) begin
      pair_pos = 0;
    end
    sect = pair_pos / SECTOR_WORDS;
    offs = pair_pos % SECTOR_WORDS;
    if (offs == seq_idx) begin
      if (sect == 0) begin
        copy0_seq = req.data_word;
      end else begin
        copy1_seq = req.data_word;
      end
    end
    if (offs < SECTOR_WORDS - 1) begin
      crc_acc = crc_fold(crc_acc, req.data_word);
      pair_pos++;
      return;
    end
    // Last word of a sector holds the stored CRC
    ok      = ((crc_acc ^ CRC_ONES) == req.data_word);
    crc_acc = CRC_ONES;
    if (sect == 0) begin
      copy0_ok = ok;
      pair_pos++;
      return;
    end
    pair_pos = 0;
    if (copy0_ok && ok) begin
      pick = !(copy0_seq > copy1_seq);
    end else begin
      pick = !copy0_ok;
    end
    verdict.current_sector = pick;
    verdict.sector0_valid  = copy0_ok;
    verdict.sector1_valid  = ok;
    verdict.needs_init     = !copy0_ok && !ok;
    verdict.current_seq    = pick ? copy1_seq : copy0_seq;
    pending_verdicts.push_back(verdict);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %08h want %08h", name, got, want));
    end
  endtask

  // Mostly short idle gaps, a few long ones; none in calm stretches
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(24, 6);
  endfunction

  task automatic push_word(input logic [31:0] w, input logic start, input bit calm);
    word_slot_t s;
    s.req.data_word  = w;
    s.req.pair_start = start;
    s.gap            = pick_gap(calm);
    sector_words.push_back(s);
  endtask

  // Queue one sector with the sequence word in place and a good or broken CRC
  task automatic queue_sector(input bit start, input bit good, input logic [31:0] seq,
                              input bit calm);
    logic [31:0] acc, w, flip;
    int          i;
    acc = CRC_ONES;
    for (i = 0; i < SECTOR_WORDS - 1; i++) begin
      w   = (i == seq_idx) ? seq : $urandom;
      acc = crc_fold(acc, w);
      push_word(w, start && (i == 0), calm);
    end
    w = acc ^ CRC_ONES;
    if (!good) begin
      flip = $urandom_range(1, 0) ? (32'h1 << $urandom_range(31, 0)) : $urandom;
      if (flip == 0) begin
        flip = 32'h8000_0000;
      end
      w = w ^ flip;
    end
    push_word(w, 1'b0, calm);
  endtask

  // Queue a complete pair; the first few walk through every validity mix
  // and sequence relation before random choice takes over
  task automatic queue_pair(input bit calm);
    logic [31:0]  s0, s1;
    bit           good0, good1, start;
    int unsigned  combo, r;
    seq_pattern_t pat;
    if (full_pairs < 4) begin
      combo = full_pairs;
    end else begin
      r     = $urandom_range(9, 0);
      combo = (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
    end
    good0 = (combo == 0) || (combo == 1);
    good1 = (combo == 0) || (combo == 2);
    pat   = seq_pattern_t'((full_pairs < 5) ? full_pairs : $urandom_range(4, 0));
    s0    = $urandom;
    s1    = $urandom;
    case (pat)
      SEQ_TIE: begin
        s1 = s0;
      end
      SEQ_FIRST_AHEAD: begin
        s0 = s1 + 1;
      end
      SEQ_SECOND_AHEAD: begin
        s1 = s0 + 1;
      end
      SEQ_EXTREMES: begin
        s0 = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
        s1 = ~s0;
      end
      default: begin
      end
    endcase
    // Without a restart the pair relies on the wrap after the previous pair
    start = !at_pair_edge || $urandom_range(1, 0);
    queue_sector(start, good0, s0, calm);
    queue_sector(1'b0, good1, s1, calm);
    full_pairs++;
    at_pair_edge = 1'b1;
  endtask

  // Queue a pair cut short, sometimes past the end of sector zero
  task automatic queue_fragment(input bit calm);
    int unsigned len, r;
    int          i;
    bit          start;
    r     = $urandom_range(9, 0);
    len   = (r < 5) ? $urandom_range(40, 1) :
            (r < 8) ? $urandom_range(1100, 1000) : $urandom_range(2047, 1);
    start = !at_pair_edge || $urandom_range(1, 0);
    for (i = 0; i < len; i++) begin
      push_word($urandom, start && (i == 0), calm);
    end
    at_pair_edge = 1'b0;
  endtask

  task automatic queue_noise(input bit calm);
    int i, len;
    len = $urandom_range(6, 1);
    for (i = 0; i < len; i++) begin
      push_word($urandom, 1'($urandom_range(1, 0)), calm);
    end
    at_pair_edge = 1'b0;
  endtask

  // Wait until every request is taken, every verdict is in and the
  // pipeline has been left unstalled long enough to empty
  task automatic wait_quiet();
    int quiet;
    quiet = 0;
    while (quiet < 8) begin
      @(negedge clk);
      if (sector_words.size() == 0 && !in_valid && pending_verdicts.size() == 0 &&
          !out_stall) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  task automatic set_seq_index(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seq_idx   = v;
  endtask

  // Queue a phase of mostly well-formed pairs among fragments and noise,
  // then hold off until it has fully drained
  task automatic run_phase(input int n);
    int          done;
    int unsigned r;
    bit          calm;
    done = 0;
    while (done < n) begin
      calm = ($urandom_range(9, 0) < 3);
      r    = $urandom_range(99, 0);
      if (r < 75) begin
        queue_pair(calm);
        done++;
      end else if (r < 90) begin
        queue_fragment(calm);
      end else begin
        queue_noise(calm);
      end
    end
    wait_quiet();
  endtask

  // Request driver: hold a stalled request, otherwise idle or advance
  always @(posedge clk) begin
    word_slot_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_sector_word(in_data);
      end
      if (!(in_valid && in_stall)) begin
        if (idle_left != 0) begin
          in_valid  <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (sector_words.size() != 0) begin
          nxt = sector_words.pop_front();
          in_valid  <= 1'b1;
          in_data   <= nxt.req;
          idle_left <= nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor: compare against the oldest prediction, stall at random
  always @(posedge clk) begin
    dscs_out_t   want;
    int unsigned r;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("verdict with none pending");
        end else begin
          want = pending_verdicts.pop_front();
          check_field("current_sector", 32'(out_data.current_sector),
                      32'(want.current_sector));
          check_field("sector0_valid", 32'(out_data.sector0_valid),
                      32'(want.sector0_valid));
          check_field("sector1_valid", 32'(out_data.sector1_valid),
                      32'(want.sector1_valid));
          check_field("needs_init", 32'(out_data.needs_init), 32'(want.needs_init));
          check_field("current_seq", out_data.current_seq, want.current_seq);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 60) begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(8, 1);
        end else if (r < 63) begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(600, 100);
        end else if (r < 92) begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(4, 1);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(30, 8);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and back-to-back restarts
    push_word(32'h0000_0000, 1'b1, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_word(32'h0000_0001, 1'b0, 1'b0);
    push_word(32'h8000_0000, 1'b0, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_word(32'h0000_0000, 1'b1, 1'b1);
    push_word(32'h5555_5555, 1'b0, 1'b1);
    push_word(32'hAAAA_AAAA, 1'b0, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_word(32'h0000_0000, 1'b0, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_word(32'hFFFF_FFFE, 1'b0, 1'b0);
    at_pair_edge = 1'b0;
    wait_quiet();

    // Sweep the sequence index over its reset value, both extremes and a random inner value
    run_phase(6);
    set_seq_index(CFG_W'(0));
    run_phase(6);
    set_seq_index(CFG_W'(1023));
    run_phase(6);
    set_seq_index(CFG_W'(1022));
    run_phase(6);
    set_seq_index(CFG_W'($urandom_range(1020, 1)));
    run_phase(6);
    set_seq_index(SEQ_IDX_RST);
    run_phase(6);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
